[src/wggc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wggc_pkg;

  localparam int FRACTION_BITS = 32;
  localparam int SERIES_TERMS  = 64;

  localparam int CHAN_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int GAMMA_W  = 24;
  localparam int GRAY_W   = 16;
  localparam int SUM_W    = WEIGHT_W + 2;
  localparam int NUM_W    = WEIGHT_W + CHAN_W + 2;

  localparam int K_W   = $clog2(SERIES_TERMS + 2);
  localparam int ONE_W = FRACTION_BITS + 1;
  localparam int T_W   = FRACTION_BITS + K_W;

  localparam int MUL_W      = T_W;
  localparam int DIGIT_W    = 8;
  localparam int MUL_DIGITS = (MUL_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MUL_BW     = MUL_DIGITS * DIGIT_W;
  localparam int PROD_W     = MUL_W + MUL_BW;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);

  localparam int DIV_W     = (T_W > NUM_W + 8) ? T_W : NUM_W + 8;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [GRAY_W-1:0] FULL_GRAY = 16'd65280;
  localparam logic [ONE_W-1:0]  ONE       = ONE_W'(1) << FRACTION_BITS;

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_WEIGHT_RED   = 2'd0;
  localparam logic [1:0] REG_WEIGHT_GREEN = 2'd1;
  localparam logic [1:0] REG_WEIGHT_BLUE  = 2'd2;
  localparam logic [1:0] REG_GAMMA_VALUE  = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 16'd77;
  localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 16'd150;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 16'd29;
  localparam logic [GAMMA_W-1:0]  GAMMA_VALUE_RST  = 24'd65536;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       frame_end_out;
  } result_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_red;
    logic [WEIGHT_W-1:0] weight_green;
    logic [WEIGHT_W-1:0] weight_blue;
    logic [GAMMA_W-1:0]  gamma_value;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ZERO, OP_FULL, OP_DIVQ, OP_WQ, OP_WX,
    OP_MIP, OP_WIP, OP_MSQ, OP_WSQ, OP_MT1, OP_WT, OP_SACC, OP_MTK,
    OP_DIVT, OP_WTD, OP_MTM, OP_WTM, OP_MP, OP_WP, OP_SHOW
  } op_t;

  typedef struct packed {
    logic sum_zero;
    logic q_full;
    logic gamma_bit;
    logic pow_last;
    logic t_zero;
    logic k_over;
    logic mul_done;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

[src/weighted_gray_gamma_correct.sv]
`timescale 1ns / 1ps
`default_nettype none
// Weighted gray with gamma correction. A pixel is taken when start is high
// and busy is low; its gray value appears on out_result for one cycle with
// out_valid, in the first cycle that busy is low again, and cannot be held
// off. One pixel is in flight at a time. How long a pixel takes depends on its
// path: a zero weight sum and a full white gray level each take a short path,
// and otherwise the time grows with the set bits of the integer exponent and
// with each binomial series term (up to 64 terms). The time is set by the
// shared bit-serial divider, one quotient bit per cycle over 39 bits, used for
// the gray level and each series term, and by the shared multiplier, one 8-bit
// digit per cycle. Configuration must be written over the APB port only while
// the block is idle; the block itself does not enforce this.
module weighted_gray_gamma_correct (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire wggc_pkg::pixel_t                    in_pixel,
  output logic                                     out_valid,
  output wggc_pkg::result_t                        out_result,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wggc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);

  wggc_pkg::cfg_t    cfg_r;
  wggc_pkg::op_t     op;
  wggc_pkg::dp_sts_t sts;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weight_red   <= wggc_pkg::WEIGHT_RED_RST;
      cfg_r.weight_green <= wggc_pkg::WEIGHT_GREEN_RST;
      cfg_r.weight_blue  <= wggc_pkg::WEIGHT_BLUE_RST;
      cfg_r.gamma_value  <= wggc_pkg::GAMMA_VALUE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        wggc_pkg::REG_WEIGHT_RED:   cfg_r.weight_red   <= pwdata[15:0];
        wggc_pkg::REG_WEIGHT_GREEN: cfg_r.weight_green <= pwdata[15:0];
        wggc_pkg::REG_WEIGHT_BLUE:  cfg_r.weight_blue  <= pwdata[15:0];
        wggc_pkg::REG_GAMMA_VALUE:  cfg_r.gamma_value  <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wggc_pkg::REG_WEIGHT_RED:   prdata = 32'(cfg_r.weight_red);
      wggc_pkg::REG_WEIGHT_GREEN: prdata = 32'(cfg_r.weight_green);
      wggc_pkg::REG_WEIGHT_BLUE:  prdata = 32'(cfg_r.weight_blue);
      wggc_pkg::REG_GAMMA_VALUE:  prdata = 32'(cfg_r.gamma_value);
      default:                    prdata = '0;
    endcase
  end

  wggc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .op    (op),
    .busy  (busy)
  );

  wggc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .pix          (in_pixel),
    .cfg          (cfg_r),
    .sts          (sts),
    .result       (out_result),
    .result_valid (out_valid)
  );

endmodule
`default_nettype wire

[src/wggc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module wggc_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [wggc_pkg::MUL_W-1:0]   a,
  input  wire logic [wggc_pkg::MUL_W-1:0]   b,
  output logic      [wggc_pkg::PROD_W-1:0]  prod,
  output logic                              done
);

  localparam int PP_W = wggc_pkg::MUL_W + wggc_pkg::DIGIT_W;

  logic [wggc_pkg::MUL_W-1:0]     a_r;
  logic [wggc_pkg::MUL_BW-1:0]    b_r;
  logic [wggc_pkg::PROD_W-1:0]    acc_r;
  logic [wggc_pkg::PROD_W-1:0]    acc_nxt;
  logic [wggc_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                           run_r;
  logic                           done_r;
  logic [PP_W-1:0]                pp;

  // one 8-bit digit of b per cycle, msb first
  always_comb begin
    pp      = PP_W'(a_r) * PP_W'(b_r[wggc_pkg::MUL_BW-1 -: wggc_pkg::DIGIT_W]);
    acc_nxt = (acc_r << wggc_pkg::DIGIT_W) + wggc_pkg::PROD_W'(pp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      a_r    <= a;
      b_r    <= wggc_pkg::MUL_BW'(b);
      acc_r  <= '0;
      cnt_r  <= '0;
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << wggc_pkg::DIGIT_W;
      if (cnt_r == wggc_pkg::MUL_CNT_W'(wggc_pkg::MUL_DIGITS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

[src/wggc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module wggc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [wggc_pkg::DIV_W-1:0]   dividend,
  input  wire logic [wggc_pkg::SUM_W-1:0]   divisor,
  output logic      [wggc_pkg::DIV_W-1:0]   quotient,
  output logic                              done
);

  localparam int SUM_W = wggc_pkg::SUM_W;
  localparam int DIV_W = wggc_pkg::DIV_W;

  logic [DIV_W-1:0]               dvd_r;
  logic [DIV_W-1:0]               quo_r;
  logic [SUM_W-1:0]               dsr_r;
  logic [SUM_W-1:0]               rem_r;
  logic [SUM_W:0]                 rem_sh;
  logic [SUM_W:0]                 rem_nxt;
  logic                           ge;
  logic [wggc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           run_r;
  logic                           done_r;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= '0;
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      rem_r <= rem_nxt[SUM_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
      dvd_r <= dvd_r << 1;
      if (cnt_r == wggc_pkg::DIV_CNT_W'(DIV_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

[src/wggc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module wggc_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wggc_pkg::op_t     op,
  input  wire wggc_pkg::pixel_t  pix,
  input  wire wggc_pkg::cfg_t    cfg,
  output wggc_pkg::dp_sts_t      sts,
  output wggc_pkg::result_t      result,
  output logic                   result_valid
);

  localparam int FB    = wggc_pkg::FRACTION_BITS;
  localparam int ONE_W = wggc_pkg::ONE_W;
  localparam int T_W   = wggc_pkg::T_W;
  localparam int MUL_W = wggc_pkg::MUL_W;
  localparam int DIV_W = wggc_pkg::DIV_W;
  localparam int SUM_W = wggc_pkg::SUM_W;
  localparam int NUM_W = wggc_pkg::NUM_W;
  localparam int K_W   = wggc_pkg::K_W;
  localparam int GP_W  = ONE_W + 8;
  localparam int QA_W  = wggc_pkg::GRAY_W + 1;

  logic [NUM_W-1:0]           num_r;
  logic [wggc_pkg::GRAY_W-1:0] q_r;
  logic [ONE_W-1:0]           ip_r;
  logic [ONE_W-1:0]           sq_r;
  logic [ONE_W-1:0]           m_r;
  logic [ONE_W-1:0]           fa_r;
  logic [T_W-1:0]             t_r;
  logic [K_W-1:0]             k_r;
  logic [2:0]                 i_r;
  logic [7:0]                 gray_r;
  logic                       fe_r;
  wggc_pkg::result_t          res_r;
  logic                       vld_r;

  logic [SUM_W-1:0]           sum;
  logic [NUM_W-1:0]           num_nxt;
  logic [FB-1:0]              f;
  logic [7:0]                 gamma_int;
  logic [MUL_W-1:0]           kf;
  logic                       mul_start;
  logic [MUL_W-1:0]           mul_a;
  logic [MUL_W-1:0]           mul_b;
  logic [wggc_pkg::PROD_W-1:0] prod;
  logic [MUL_W-1:0]           mul_hi;
  logic                       mul_done;
  logic                       div_start;
  logic [DIV_W-1:0]           div_dvd;
  logic [SUM_W-1:0]           div_dsr;
  logic [DIV_W-1:0]           quo;
  logic                       div_done;
  logic [GP_W-1:0]            gp;
  logic [8:0]                 g9;
  logic [QA_W-1:0]            q_adj;
  logic [FB-1:0]              x_fx;

  always_comb begin
    sum = SUM_W'(cfg.weight_red) + SUM_W'(cfg.weight_green) + SUM_W'(cfg.weight_blue);
    num_nxt = NUM_W'(cfg.weight_red) * NUM_W'(pix.red)
            + NUM_W'(cfg.weight_green) * NUM_W'(pix.green)
            + NUM_W'(cfg.weight_blue) * NUM_W'(pix.blue);
    f         = FB'(cfg.gamma_value[15:0]) << (FB - 16);
    gamma_int = cfg.gamma_value[23:16];
    // k - f for the next series term, k in the integer bits
    kf        = (MUL_W'(k_r) << FB) - MUL_W'(f);
    mul_hi    = prod[FB +: MUL_W];
    gp        = {mul_hi[ONE_W-1:0], 8'd0} - GP_W'(mul_hi[ONE_W-1:0]);
    g9        = gp[FB +: 9];
  end

  // base q / 255.0 in the fraction bits: q * 2^(FB-8) / 255 splits into
  // q * (1 + 2^8 + 2^16 + ...) plus q / 255, with FB a multiple of 8
  always_comb begin
    q_adj = QA_W'(q_r) + QA_W'(q_r >> 8) + QA_W'(1);
    x_fx  = FB'(q_adj[QA_W-1:8]);
    for (int s = 0; s < FB - 8; s += 8) begin
      x_fx = x_fx + (FB'(q_r) << s);
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    case (op)
      wggc_pkg::OP_MIP: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(ip_r);
        mul_b     = MUL_W'(sq_r);
      end
      wggc_pkg::OP_MSQ: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(sq_r);
        mul_b     = MUL_W'(sq_r);
      end
      wggc_pkg::OP_MT1: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(f);
        mul_b     = MUL_W'(m_r);
      end
      wggc_pkg::OP_MTK: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(t_r);
        mul_b     = kf;
      end
      wggc_pkg::OP_MTM: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(t_r);
        mul_b     = MUL_W'(m_r);
      end
      wggc_pkg::OP_MP: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(ip_r);
        mul_b     = MUL_W'(fa_r);
      end
      wggc_pkg::OP_DIVQ: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(num_r) << 8;
        div_dsr   = sum;
      end
      wggc_pkg::OP_DIVT: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(t_r);
        div_dsr   = SUM_W'(k_r) + SUM_W'(1);
      end
      default: begin
      end
    endcase
  end

  wggc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  wggc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= (op == wggc_pkg::OP_SHOW);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      wggc_pkg::OP_LOAD: begin
        num_r <= num_nxt;
        fe_r  <= pix.frame_end;
      end
      wggc_pkg::OP_ZERO: gray_r <= 8'd0;
      wggc_pkg::OP_FULL: gray_r <= 8'd255;
      wggc_pkg::OP_WQ:   q_r <= quo[wggc_pkg::GRAY_W-1:0];
      wggc_pkg::OP_WX: begin
        sq_r <= ONE_W'(x_fx);
        m_r  <= wggc_pkg::ONE - ONE_W'(x_fx);
        ip_r <= wggc_pkg::ONE;
        fa_r <= wggc_pkg::ONE;
        i_r  <= 3'd0;
        k_r  <= K_W'(1);
      end
      wggc_pkg::OP_WIP: ip_r <= mul_hi[ONE_W-1:0];
      wggc_pkg::OP_WSQ: begin
        sq_r <= mul_hi[ONE_W-1:0];
        i_r  <= i_r + 3'd1;
      end
      wggc_pkg::OP_WT:  t_r <= mul_hi[T_W-1:0];
      wggc_pkg::OP_SACC: begin
        // series sum floors at zero
        if (t_r >= T_W'(fa_r)) begin
          fa_r <= '0;
        end else begin
          fa_r <= fa_r - t_r[ONE_W-1:0];
        end
      end
      wggc_pkg::OP_WTD: t_r <= quo[T_W-1:0];
      wggc_pkg::OP_WTM: begin
        t_r <= mul_hi[T_W-1:0];
        k_r <= k_r + K_W'(1);
      end
      wggc_pkg::OP_WP:   gray_r <= g9[8] ? 8'd255 : g9[7:0];
      wggc_pkg::OP_SHOW: res_r <= '{gray: gray_r, frame_end_out: fe_r};
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.sum_zero  = (sum == '0);
    sts.q_full    = (q_r >= wggc_pkg::FULL_GRAY);
    sts.gamma_bit = gamma_int[i_r];
    sts.pow_last  = (i_r == 3'd7);
    sts.t_zero    = (t_r == '0);
    sts.k_over    = (k_r > K_W'(wggc_pkg::SERIES_TERMS));
    sts.mul_done  = mul_done;
    sts.div_done  = div_done;
  end

  assign result       = res_r;
  assign result_valid = vld_r;

endmodule
`default_nettype wire

[src/wggc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module wggc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire wggc_pkg::dp_sts_t  sts,
  output wggc_pkg::op_t           op,
  output logic                    busy
);

  typedef enum logic [19:0] {
    S_IDLE = 20'b1 << 0,
    S_DIVQ = 20'b1 << 1,
    S_WQ   = 20'b1 << 2,
    S_CHKQ = 20'b1 << 3,
    S_IP   = 20'b1 << 5,
    S_WIP  = 20'b1 << 6,
    S_SQ   = 20'b1 << 7,
    S_WSQ  = 20'b1 << 8,
    S_T1   = 20'b1 << 9,
    S_WT1  = 20'b1 << 10,
    S_SER  = 20'b1 << 11,
    S_MTK  = 20'b1 << 12,
    S_WTK  = 20'b1 << 13,
    S_DIVT = 20'b1 << 14,
    S_WTD  = 20'b1 << 15,
    S_MTM  = 20'b1 << 16,
    S_WTM  = 20'b1 << 17,
    S_WP   = 20'b1 << 18,
    S_SHOW = 20'b1 << 19
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = wggc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = wggc_pkg::OP_LOAD;
          state_nxt = S_DIVQ;
        end
      end
      S_DIVQ: begin
        if (sts.sum_zero) begin
          op        = wggc_pkg::OP_ZERO;
          state_nxt = S_SHOW;
        end else begin
          op        = wggc_pkg::OP_DIVQ;
          state_nxt = S_WQ;
        end
      end
      S_WQ: begin
        if (sts.div_done) begin
          op        = wggc_pkg::OP_WQ;
          state_nxt = S_CHKQ;
        end
      end
      S_CHKQ: begin
        if (sts.q_full) begin
          op        = wggc_pkg::OP_FULL;
          state_nxt = S_SHOW;
        end else begin
          op        = wggc_pkg::OP_WX;
          state_nxt = S_IP;
        end
      end
      // square-and-multiply over the integer exponent bits, lsb first
      S_IP: begin
        if (sts.gamma_bit) begin
          op        = wggc_pkg::OP_MIP;
          state_nxt = S_WIP;
        end else begin
          op        = wggc_pkg::OP_MSQ;
          state_nxt = S_WSQ;
        end
      end
      S_WIP: begin
        if (sts.mul_done) begin
          op        = wggc_pkg::OP_WIP;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        op        = wggc_pkg::OP_MSQ;
        state_nxt = S_WSQ;
      end
      S_WSQ: begin
        if (sts.mul_done) begin
          op        = wggc_pkg::OP_WSQ;
          state_nxt = sts.pow_last ? S_T1 : S_IP;
        end
      end
      S_T1: begin
        op        = wggc_pkg::OP_MT1;
        state_nxt = S_WT1;
      end
      S_WT1: begin
        if (sts.mul_done) begin
          op        = wggc_pkg::OP_WT;
          state_nxt = S_SER;
        end
      end
      S_SER: begin
        if (sts.t_zero || sts.k_over) begin
          op        = wggc_pkg::OP_MP;
          state_nxt = S_WP;
        end else begin
          op        = wggc_pkg::OP_SACC;
          state_nxt = S_MTK;
        end
      end
      S_MTK: begin
        op        = wggc_pkg::OP_MTK;
        state_nxt = S_WTK;
      end
      S_WTK: begin
        if (sts.mul_done) begin
          op        = wggc_pkg::OP_WT;
          state_nxt = S_DIVT;
        end
      end
      S_DIVT: begin
        op        = wggc_pkg::OP_DIVT;
        state_nxt = S_WTD;
      end
      S_WTD: begin
        if (sts.div_done) begin
          op        = wggc_pkg::OP_WTD;
          state_nxt = S_MTM;
        end
      end
      S_MTM: begin
        op        = wggc_pkg::OP_MTM;
        state_nxt = S_WTM;
      end
      S_WTM: begin
        if (sts.mul_done) begin
          op        = wggc_pkg::OP_WTM;
          state_nxt = S_SER;
        end
      end
      S_WP: begin
        if (sts.mul_done) begin
          op        = wggc_pkg::OP_WP;
          state_nxt = S_SHOW;
        end
      end
      S_SHOW: begin
        op        = wggc_pkg::OP_SHOW;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[src/wggc_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module wggc_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // a taken beat always starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted pixel did not raise busy");

  // the result beat shows only once the block is free again
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // one result beat per pixel
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

  // finishing a pixel always delivers its beat
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("pixel finished without result beat");

endmodule

bind weighted_gray_gamma_correct wggc_chk u_wggc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire
